>>> design/fpd_pkg.sv
// Shared constants, types and command/status structs for the packet deframer.
`timescale 1ns / 1ps

package fpd_pkg;

    // Defaults
    localparam int unsigned DEF_MAX_PAYLOAD  = 63;
    localparam logic [7:0]  DEF_START_MARKER = 8'h7E;

    // Frame layout
    localparam int unsigned HDR_BYTES = 4;
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned SEQ_W     = 5;
    localparam int unsigned KIND_W    = 4;
    localparam int unsigned COUNT_W   = 6;

    // Stream widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned OUT_TUSER_W = 2;

    typedef logic [7:0]        t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [SEQ_W-1:0]  t_seq;
    typedef logic [KIND_W-1:0] t_kind;

    // Controller to datapath
    typedef struct packed {
        logic accept_byte;   // input transaction this cycle
        logic clear_frame;   // drop per-buffer state
        logic load_single;   // load error / empty-frame item
        logic rd_issue;      // read payload store at current index
        logic load_data;     // load payload item from read register
        logic idx_clr;
        logic idx_inc;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bad;           // frame rejected
        logic empty;         // zero length frame
        logic last_idx;      // current index is the final payload byte
        logic out_free;      // output register can take an item
    } t_dp_stat;

endpackage

>>> design/fpd_dp.sv
// Deframer datapath: header capture, payload store, checksum and output register.
`timescale 1ns / 1ps

module fpd_dp #(
    parameter int unsigned MAX_PAYLOAD = fpd_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  logic [7:0]            i_rx_byte,
    input  fpd_pkg::t_dp_cmd      i_cmd,
    output fpd_pkg::t_dp_stat     o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [7:0]            o_payload_byte,
    output logic                  o_has_payload,
    output logic [fpd_pkg::SEQ_W-1:0]   o_frame_seq,
    output logic [fpd_pkg::KIND_W-1:0]  o_frame_kind,
    output logic [fpd_pkg::COUNT_W-1:0] o_payload_count,
    output logic                  o_status,
    output logic                  o_last_item
);

    // Position counter saturates above the longest frame that can be accepted
    localparam int unsigned POS_W = $clog2(2 * MAX_PAYLOAD + 6);
    localparam int unsigned CMP_W = ((POS_W > fpd_pkg::LEN_W) ? POS_W : fpd_pkg::LEN_W) + 2;
    localparam int unsigned AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic [7:0]               r_start_marker;
    logic [POS_W-1:0]         r_pos;
    fpd_pkg::t_len            r_len;
    fpd_pkg::t_seq            r_seq;
    fpd_pkg::t_kind           r_kind;
    logic [7:0]               r_rx_sum;
    logic [7:0]               r_run_sum;
    logic                     r_err;
    logic [AW-1:0]            r_idx;
    logic [7:0]               r_rd_data;
    logic [7:0]               r_mem [MAX_PAYLOAD];

    logic                     r_out_valid;
    logic [7:0]               r_out_byte;
    logic                     r_out_has;
    fpd_pkg::t_seq            r_out_seq;
    fpd_pkg::t_kind           r_out_kind;
    logic [fpd_pkg::COUNT_W-1:0] r_out_count;
    logic                     r_out_status;
    logic                     r_out_last;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] off;
    logic [CMP_W-1:0] data_idx;
    logic             store_we;
    logic [7:0]       sum;
    logic             bad;

    assign pos_ext  = CMP_W'(r_pos);
    assign len_ext  = CMP_W'(r_len);
    assign off      = pos_ext - CMP_W'(fpd_pkg::HDR_BYTES);
    assign data_idx = off >> 1;
    assign store_we = i_cmd.accept_byte && (pos_ext >= CMP_W'(fpd_pkg::HDR_BYTES))
                      && !off[0] && (data_idx < len_ext)
                      && (len_ext <= CMP_W'(MAX_PAYLOAD));

    assign sum = r_run_sum + 8'(r_len) + 8'(r_seq) + 8'(r_kind);
    assign bad = r_err
                 || (pos_ext < CMP_W'(fpd_pkg::HDR_BYTES))
                 || (len_ext > CMP_W'(MAX_PAYLOAD))
                 || (pos_ext < (CMP_W'(fpd_pkg::HDR_BYTES) + (len_ext << 1)))
                 || (~sum != r_rx_sum);

    assign o_stat.bad      = bad;
    assign o_stat.empty    = (r_len == '0);
    assign o_stat.last_idx = ((CMP_W'(r_idx) + CMP_W'(1)) == len_ext);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Configuration and per-buffer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= fpd_pkg::DEF_START_MARKER;
            r_pos          <= '0;
            r_len          <= '0;
            r_seq          <= '0;
            r_kind         <= '0;
            r_rx_sum       <= '0;
            r_run_sum      <= '0;
            r_err          <= 1'b0;
            r_idx          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_marker <= i_cfg_wr_data;
            end
            if (i_cmd.clear_frame) begin
                r_pos     <= '0;
                r_len     <= '0;
                r_seq     <= '0;
                r_kind    <= '0;
                r_rx_sum  <= '0;
                r_run_sum <= '0;
                r_err     <= 1'b0;
            end else if (i_cmd.accept_byte) begin
                if (r_pos == POS_W'(0)) begin
                    if (i_rx_byte != r_start_marker) begin
                        r_err <= 1'b1;
                    end
                end else if (r_pos == POS_W'(1)) begin
                    r_len    <= i_rx_byte[7:1];
                    r_seq[4] <= i_rx_byte[0];
                end else if (r_pos == POS_W'(2)) begin
                    r_seq[3:0] <= i_rx_byte[7:4];
                    r_kind     <= i_rx_byte[3:0];
                end else if (r_pos == POS_W'(3)) begin
                    r_rx_sum <= i_rx_byte;
                end else if (store_we) begin
                    r_run_sum <= r_run_sum + i_rx_byte;
                end
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    // Payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_mem[data_idx[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_single || i_cmd.load_data) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_out_byte   <= '0;
            r_out_has    <= 1'b0;
            r_out_seq    <= bad ? '0 : r_seq;
            r_out_kind   <= bad ? '0 : r_kind;
            r_out_count  <= '0;
            r_out_status <= bad;
            r_out_last   <= 1'b1;
        end else if (i_cmd.load_data) begin
            r_out_byte   <= r_rd_data;
            r_out_has    <= 1'b1;
            r_out_seq    <= r_seq;
            r_out_kind   <= r_kind;
            r_out_count  <= r_len[fpd_pkg::COUNT_W-1:0];
            r_out_status <= 1'b0;
            r_out_last   <= o_stat.last_idx;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_out_byte;
    assign o_has_payload   = r_out_has;
    assign o_frame_seq     = r_out_seq;
    assign o_frame_kind    = r_out_kind;
    assign o_payload_count = r_out_count;
    assign o_status        = r_out_status;
    assign o_last_item     = r_out_last;

endmodule

>>> design/fpd_ctrl.sv
// Deframer controller: receive, check and payload read-out sequencing.
`timescale 1ns / 1ps

module fpd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    input  fpd_pkg::t_dp_stat  i_stat,
    output fpd_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_RX    = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_RX);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.accept_byte = accept;
        unique case (r_state)
            S_RX: begin
                if (accept && i_in_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.bad || i_stat.empty) begin
                    if (i_stat.out_free) begin
                        o_cmd.load_single = 1'b1;
                        o_cmd.clear_frame = 1'b1;
                        n_state = S_RX;
                    end
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_data = 1'b1;
                    if (i_stat.last_idx) begin
                        o_cmd.clear_frame = 1'b1;
                        n_state = S_RX;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/framed_packet_deframer_core.sv
// Top level of the framed packet deframer.
`timescale 1ns / 1ps

// Framed packet deframer. A buffer streams in one byte per transaction on
// the slave side, s_axis_tlast on its final byte. Byte 0 must match the
// start marker (i_cfg_wr_data written with i_cfg_wr_en, reset 0x7E), bytes
// 1 and 2 carry the 7-bit length, 5-bit sequence and 4-bit type, byte 3
// the checksum, then data bytes at even offsets with a pad byte after each.
// Bytes beyond the frame are dropped. After the final byte the block emits
// either every data byte with the header fields (tlast on the last), one
// empty-frame item, or one error item (tuser bit 1 and tlast set, all else
// zero).
// Throughput: one byte per cycle while a buffer is received. The final
// byte is followed by a check state, in which an error or empty-frame
// item is loaded straight into the output register once it is free;
// payload read-out then alternates a read state, in which the registered
// read port of the payload store fetches a data byte, and a load state,
// in which it enters the output register. The slave side is stalled from
// the final byte until the last result is loaded; that result may still
// be waiting on m_axis_tready while the next buffer streams in.
module framed_packet_deframer_core #(
    parameter int unsigned MAX_PAYLOAD = fpd_pkg::DEF_MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Start marker register
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,

    // Received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [fpd_pkg::IN_TDATA_W-1:0] s_axis_tdata, // [7:0] rx_byte
    input  logic        s_axis_tlast,                    // buffer_end

    // Recovered items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [12:8] frame_seq, [16:13] frame_kind,
    // [22:17] payload_count, [23] zero
    output logic [fpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] has_payload, [1] status
    output logic [fpd_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic        m_axis_tlast                     // last_item
);

    fpd_pkg::t_dp_cmd  cmd;
    fpd_pkg::t_dp_stat stat;

    logic [7:0]                      payload_byte;
    logic                            has_payload;
    logic [fpd_pkg::SEQ_W-1:0]       frame_seq;
    logic [fpd_pkg::KIND_W-1:0]      frame_kind;
    logic [fpd_pkg::COUNT_W-1:0]     payload_count;
    logic                            status;

    fpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fpd_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_rx_byte       (s_axis_tdata[7:0]),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_payload_byte  (payload_byte),
        .o_has_payload   (has_payload),
        .o_frame_seq     (frame_seq),
        .o_frame_kind    (frame_kind),
        .o_payload_count (payload_count),
        .o_status        (status),
        .o_last_item     (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, payload_count, frame_kind, frame_seq, payload_byte};
    assign m_axis_tuser = {status, has_payload};

endmodule
